// File: rtl/ffsb_pkg.sv
// Package for the FIRST/FOLLOW set builder: sizes, codes and the
// command and status structs between the controller and the datapath.
// No dependencies.
package ffsb_pkg;

    // Sizes of the grammar store and the symbol space.
    localparam int MAX_RULES    = 64;
    localparam int MAX_RULE_LEN = 8;
    localparam int NUM_SYMBOLS  = 32;

    localparam int SYM_W   = 5;
    localparam int SET_W   = 32;
    localparam int RIDX_W  = 6;
    localparam int RCNT_W  = 7;
    localparam int POS_W   = 4;
    localparam int PIDX_W  = 3;
    localparam int ADDR_W  = RIDX_W + PIDX_W;
    localparam int SADDR_W = SYM_W + 1;
    localparam int CIDX_W  = 8;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_LHS_TERM  = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_BAD_START = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_TERM_COUNT = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_START_SYM  = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_END_SYM    = 8'd2;

    // Datapath operations.
    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_RD_FIRST   = 4'd1;
    localparam logic [3:0] OP_UPD_FIRST  = 4'd2;
    localparam logic [3:0] OP_SEED_START = 4'd3;
    localparam logic [3:0] OP_RD_SEED    = 4'd4;
    localparam logic [3:0] OP_UPD_SEED   = 4'd5;
    localparam logic [3:0] OP_RD_PROP    = 4'd6;
    localparam logic [3:0] OP_UPD_PROP   = 4'd7;
    localparam logic [3:0] OP_RD_ROW     = 4'd8;
    localparam logic [3:0] OP_EMIT_ROW   = 4'd9;
    localparam logic [3:0] OP_EMIT_FAULT = 4'd10;

    // Commands from the controller.
    typedef struct packed {
        logic              load_en;
        logic              check;
        logic              clear_sets;
        logic              clr_changed;
        logic              done;
        logic [RCNT_W-1:0] rule;
        logic [POS_W-1:0]  pos;
        logic              lat_n;
        logic              lat_m;
        logic              lat_s;
        logic              shift_n;
        logic [3:0]        op;
        logic              row_kind;
        logic [SYM_W-1:0]  row_sym;
        logic              row_last;
    } t_cmd;

    // Status back to the controller.
    typedef struct packed {
        logic              fault;
        logic              changed;
        logic              out_free;
        logic [RCNT_W-1:0] rule_total;
        logic [POS_W-1:0]  len;
        logic [SYM_W-1:0]  term_count;
    } t_stat;

endpackage

// File: rtl/ffsb_ctrl.sv
// Controller of the FIRST/FOLLOW set builder: sequences loading, the
// start check, the three set passes and row emission. Uses ffsb_pkg.
module ffsb_ctrl import ffsb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_eog,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_CHK2  = 5'd2;
    localparam logic [4:0] S_ERR   = 5'd3;
    localparam logic [4:0] S_F0    = 5'd4;
    localparam logic [4:0] S_F1    = 5'd5;
    localparam logic [4:0] S_F2    = 5'd6;
    localparam logic [4:0] S_F3    = 5'd7;
    localparam logic [4:0] S_F4    = 5'd8;
    localparam logic [4:0] S_FEND  = 5'd9;
    localparam logic [4:0] S_L0    = 5'd10;
    localparam logic [4:0] S_L1    = 5'd11;
    localparam logic [4:0] S_L2    = 5'd12;
    localparam logic [4:0] S_L3    = 5'd13;
    localparam logic [4:0] S_L4    = 5'd14;
    localparam logic [4:0] S_L5    = 5'd15;
    localparam logic [4:0] S_LNEXT = 5'd16;
    localparam logic [4:0] S_P0    = 5'd17;
    localparam logic [4:0] S_P1    = 5'd18;
    localparam logic [4:0] S_P2    = 5'd19;
    localparam logic [4:0] S_P3    = 5'd20;
    localparam logic [4:0] S_P4    = 5'd21;
    localparam logic [4:0] S_PEND  = 5'd22;
    localparam logic [4:0] S_O0    = 5'd23;
    localparam logic [4:0] S_O1    = 5'd24;

    logic [4:0]        r_state, n_state;
    logic [RCNT_W-1:0] r_rule, n_rule;
    logic [POS_W-1:0]  r_j, n_j;
    logic [SYM_W-1:0]  r_row, n_row;
    logic              r_kind, n_kind;
    logic              more_rules;

    assign more_rules = (r_rule + RCNT_W'(1)) < i_stat.rule_total;

    // Next state and command decode.
    always_comb begin
        n_state             = r_state;
        n_rule              = r_rule;
        n_j                 = r_j;
        n_row               = r_row;
        n_kind              = r_kind;
        o_in_ready          = 1'b0;
        o_cmd               = '0;
        o_cmd.rule          = r_rule;
        o_cmd.op            = OP_NONE;
        o_cmd.row_kind      = r_kind;
        o_cmd.row_sym       = r_row;
        o_cmd.row_last      = (r_row == SYM_W'(NUM_SYMBOLS - 1)) && r_kind;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_en = 1'b1;
                    if (i_eog) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_CHK2;
            end
            S_CHK2: begin
                if (i_stat.fault) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.clear_sets  = 1'b1;
                    o_cmd.clr_changed = 1'b1;
                    n_rule            = '0;
                    n_state           = S_F0;
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.op   = OP_EMIT_FAULT;
                    o_cmd.done = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            // FIRST pass: each production steps through states S_F0 to S_F4.
            S_F0: begin
                o_cmd.pos = POS_W'(0);
                n_state   = S_F1;
            end
            S_F1: begin
                o_cmd.lat_n = 1'b1;
                o_cmd.pos   = POS_W'(1);
                n_state     = S_F2;
            end
            S_F2: begin
                o_cmd.lat_s = 1'b1;
                n_state     = S_F3;
            end
            S_F3: begin
                o_cmd.op = OP_RD_FIRST;
                n_state  = S_F4;
            end
            S_F4: begin
                o_cmd.op = OP_UPD_FIRST;
                if (more_rules) begin
                    n_rule  = r_rule + RCNT_W'(1);
                    n_state = S_F0;
                end else begin
                    n_state = S_FEND;
                end
            end
            S_FEND: begin
                n_rule = '0;
                if (i_stat.changed) begin
                    o_cmd.clr_changed = 1'b1;
                    n_state           = S_F0;
                end else begin
                    o_cmd.op = OP_SEED_START;
                    n_state  = S_L0;
                end
            end
            // FOLLOW seeding from the symbol after each nonterminal.
            S_L0: begin
                n_state = S_L1;
            end
            S_L1: begin
                if (i_stat.len < POS_W'(3)) begin
                    n_state = S_LNEXT;
                end else begin
                    n_j       = POS_W'(1);
                    o_cmd.pos = POS_W'(1);
                    n_state   = S_L2;
                end
            end
            S_L2: begin
                o_cmd.lat_n = 1'b1;
                o_cmd.pos   = r_j + POS_W'(1);
                n_state     = S_L3;
            end
            S_L3: begin
                o_cmd.lat_s = 1'b1;
                n_state     = S_L4;
            end
            S_L4: begin
                o_cmd.op = OP_RD_SEED;
                n_state  = S_L5;
            end
            S_L5: begin
                o_cmd.op = OP_UPD_SEED;
                if ((r_j + POS_W'(2)) < i_stat.len) begin
                    n_j           = r_j + POS_W'(1);
                    o_cmd.shift_n = 1'b1;
                    o_cmd.pos     = r_j + POS_W'(2);
                    n_state       = S_L3;
                end else begin
                    n_state = S_LNEXT;
                end
            end
            S_LNEXT: begin
                if (more_rules) begin
                    n_rule  = r_rule + RCNT_W'(1);
                    n_state = S_L0;
                end else begin
                    n_rule            = '0;
                    o_cmd.clr_changed = 1'b1;
                    n_state           = S_P0;
                end
            end
            // FOLLOW propagation from left side to last symbol.
            S_P0: begin
                o_cmd.pos = POS_W'(0);
                n_state   = S_P1;
            end
            S_P1: begin
                o_cmd.lat_m = 1'b1;
                o_cmd.pos   = i_stat.len - POS_W'(1);
                n_state     = S_P2;
            end
            S_P2: begin
                o_cmd.lat_n = 1'b1;
                n_state     = S_P3;
            end
            S_P3: begin
                o_cmd.op = OP_RD_PROP;
                n_state  = S_P4;
            end
            S_P4: begin
                o_cmd.op = OP_UPD_PROP;
                if (more_rules) begin
                    n_rule  = r_rule + RCNT_W'(1);
                    n_state = S_P0;
                end else begin
                    n_state = S_PEND;
                end
            end
            S_PEND: begin
                n_rule = '0;
                if (i_stat.changed) begin
                    o_cmd.clr_changed = 1'b1;
                    n_state           = S_P0;
                end else begin
                    n_row   = i_stat.term_count;
                    n_kind  = 1'b0;
                    n_state = S_O0;
                end
            end
            // Row emission, FIRST then FOLLOW for each nonterminal.
            S_O0: begin
                o_cmd.op = OP_RD_ROW;
                n_state  = S_O1;
            end
            S_O1: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT_ROW;
                    if (o_cmd.row_last) begin
                        o_cmd.done = 1'b1;
                        n_state    = S_LOAD;
                    end else begin
                        if (r_kind) n_row = r_row + SYM_W'(1);
                        n_kind  = ~r_kind;
                        n_state = S_O0;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_rule  <= '0;
            r_j     <= '0;
            r_row   <= '0;
            r_kind  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rule  <= n_rule;
            r_j     <= n_j;
            r_row   <= n_row;
            r_kind  <= n_kind;
        end
    end

endmodule

// File: rtl/ffsb_datapath.sv
// Datapath of the FIRST/FOLLOW set builder: configuration registers,
// grammar store, set memory and output register. Uses ffsb_pkg.
module ffsb_datapath import ffsb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [SYM_W-1:0]  i_cfg_data,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic              i_end_of_production,
    input  logic              i_end_of_grammar,
    input  logic              i_out_ready,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_out_valid,
    output logic              o_table_kind,
    output logic [SYM_W-1:0]  o_row_symbol,
    output logic [SET_W-1:0]  o_members,
    output logic [2:0]        o_status,
    output logic              o_last
);

    // Configuration.
    logic [SYM_W-1:0] r_term_count, r_start_sym, r_end_sym;

    // Load bookkeeping.
    logic [RCNT_W-1:0] r_rule_count, n_rule_count;
    logic [POS_W-1:0]  r_fill, n_fill;
    logic [2:0]        r_fault, n_fault;
    logic              r_prep, n_prep;
    logic [SYM_W-1:0]  r_lhs0, r_sym01;
    logic [POS_W-1:0]  r_len0;
    logic              sym_wr, len_wr;
    logic [POS_W-1:0]  fill_inc;

    // Grammar store.
    logic [SYM_W-1:0]  r_rule_mem [MAX_RULES*MAX_RULE_LEN];
    logic [POS_W-1:0]  r_len_mem [MAX_RULES];
    logic [SYM_W-1:0]  r_rd_sym;
    logic [POS_W-1:0]  r_rd_len;
    logic [RCNT_W-1:0] phys_rule;
    logic              virt_rule;

    // Set memory, FIRST in the lower half and FOLLOW in the upper half.
    logic [SET_W-1:0]   r_set_mem [2*NUM_SYMBOLS];
    logic [2*NUM_SYMBOLS-1:0] r_set_vld;
    logic [SET_W-1:0]   r_rd_a, r_rd_b;
    logic               r_rd_a_vld, r_rd_b_vld;
    logic [SET_W-1:0]   set_a, set_b, first_s;
    logic [SADDR_W-1:0] addr_a, addr_b, w_addr;
    logic [SET_W-1:0]   w_data;
    logic               w_en, rd_en, set_changed;
    logic               r_changed;

    // Operand latches.
    logic [SYM_W-1:0] r_n, r_m, r_s;
    logic             term_n, term_s;

    logic r_out_valid;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= SYM_W'(16);
            r_start_sym  <= SYM_W'(31);
            r_end_sym    <= SYM_W'(0);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TERM_COUNT: r_term_count <= i_cfg_data;
                CFG_START_SYM:  r_start_sym  <= i_cfg_data;
                CFG_END_SYM:    r_end_sym    <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    assign fill_inc = (r_fill < POS_W'(MAX_RULE_LEN)) ? r_fill + POS_W'(1)
                                                      : POS_W'(MAX_RULE_LEN);

    // Loading, the start check and end of run; the first fault wins.
    always_comb begin
        n_rule_count = r_rule_count;
        n_fill       = r_fill;
        n_fault      = r_fault;
        n_prep       = r_prep;
        sym_wr       = 1'b0;
        len_wr       = 1'b0;
        if (i_cmd.load_en) begin
            if (r_fill == '0 && i_symbol < r_term_count && n_fault == ST_OK)
                n_fault = ST_LHS_TERM;
            if (r_rule_count >= RCNT_W'(MAX_RULES) || r_fill >= POS_W'(MAX_RULE_LEN)) begin
                if (n_fault == ST_OK) n_fault = ST_OVERFLOW;
            end else begin
                sym_wr = 1'b1;
            end
            n_fill = fill_inc;
            if (i_end_of_production || i_end_of_grammar) begin
                if (fill_inc < POS_W'(2) && n_fault == ST_OK) n_fault = ST_SHORT;
                if (r_rule_count < RCNT_W'(MAX_RULES)) begin
                    len_wr       = 1'b1;
                    n_rule_count = r_rule_count + RCNT_W'(1);
                end
                n_fill = '0;
            end
        end
        if (i_cmd.check && r_fault == ST_OK) begin
            if (r_lhs0 == r_start_sym) begin
                if (r_len0 != POS_W'(2) || r_sym01 < r_term_count)
                    n_fault = ST_BAD_START;
            end else if (r_rule_count >= RCNT_W'(MAX_RULES)) begin
                n_fault = ST_OVERFLOW;
            end else begin
                n_prep = 1'b1;
            end
        end
        if (i_cmd.done) begin
            n_rule_count = '0;
            n_fill       = '0;
            n_fault      = ST_OK;
            n_prep       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_count <= '0;
            r_fill       <= '0;
            r_fault      <= ST_OK;
            r_prep       <= 1'b0;
        end else begin
            r_rule_count <= n_rule_count;
            r_fill       <= n_fill;
            r_fault      <= n_fault;
            r_prep       <= n_prep;
        end
    end

    // First production's fields, kept for the start check.
    always_ff @(posedge i_clk) begin
        if (sym_wr && r_rule_count == '0) begin
            if (r_fill == POS_W'(0)) r_lhs0  <= i_symbol;
            if (r_fill == POS_W'(1)) r_sym01 <= i_symbol;
        end
        if (len_wr && r_rule_count == '0) r_len0 <= fill_inc;
    end

    // Grammar store; the prepended START production sits in front.
    assign phys_rule = i_cmd.rule - RCNT_W'(r_prep);
    assign virt_rule = r_prep && (i_cmd.rule == '0);

    always_ff @(posedge i_clk) begin
        if (sym_wr)
            r_rule_mem[{r_rule_count[RIDX_W-1:0], r_fill[PIDX_W-1:0]}] <= i_symbol;
        if (virt_rule)
            r_rd_sym <= (i_cmd.pos == '0) ? r_start_sym : r_lhs0;
        else
            r_rd_sym <= r_rule_mem[{phys_rule[RIDX_W-1:0], i_cmd.pos[PIDX_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (len_wr)
            r_len_mem[r_rule_count[RIDX_W-1:0]] <= fill_inc;
        if (virt_rule)
            r_rd_len <= POS_W'(2);
        else
            r_rd_len <= r_len_mem[phys_rule[RIDX_W-1:0]];
    end

    // Operand latches from the grammar store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_n)        r_n <= r_rd_sym;
        else if (i_cmd.shift_n) r_n <= r_s;
        if (i_cmd.lat_m)        r_m <= r_rd_sym;
        if (i_cmd.lat_s)        r_s <= r_rd_sym;
    end

    assign term_n = r_n < r_term_count;
    assign term_s = r_s < r_term_count;

    // Set read addresses for each operation.
    always_comb begin
        addr_a = {1'b0, r_n};
        addr_b = {1'b0, r_s};
        rd_en  = 1'b1;
        case (i_cmd.op)
            OP_RD_FIRST: begin
                addr_a = {1'b0, r_n};
                addr_b = {1'b0, r_s};
            end
            OP_RD_SEED: begin
                addr_a = {1'b1, r_n};
                addr_b = {1'b0, r_s};
            end
            OP_RD_PROP: begin
                addr_a = {1'b1, r_n};
                addr_b = {1'b1, r_m};
            end
            OP_RD_ROW: begin
                addr_a = {i_cmd.row_kind, i_cmd.row_sym};
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign set_a   = r_rd_a_vld ? r_rd_a : '0;
    assign set_b   = r_rd_b_vld ? r_rd_b : '0;
    assign first_s = term_s ? (SET_W'(1) << r_s) : set_b;

    // Set updates.
    always_comb begin
        w_en        = 1'b0;
        w_addr      = {1'b0, r_n};
        w_data      = set_a | first_s;
        set_changed = 1'b0;
        case (i_cmd.op)
            OP_UPD_FIRST: begin
                w_addr = {1'b0, r_n};
                w_data = set_a | first_s;
                if (w_data != set_a) begin
                    w_en        = 1'b1;
                    set_changed = 1'b1;
                end
            end
            OP_SEED_START: begin
                w_en   = 1'b1;
                w_addr = {1'b1, r_start_sym};
                w_data = SET_W'(1) << r_end_sym;
            end
            OP_UPD_SEED: begin
                w_addr = {1'b1, r_n};
                w_data = set_a | first_s;
                w_en   = ~term_n;
            end
            OP_UPD_PROP: begin
                w_addr = {1'b1, r_n};
                w_data = set_a | set_b;
                if (!term_n && r_m != r_n && w_data != set_a) begin
                    w_en        = 1'b1;
                    set_changed = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Set memory with two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_en) r_set_mem[w_addr] <= w_data;
        if (rd_en) begin
            r_rd_a <= r_set_mem[addr_a];
            r_rd_b <= r_set_mem[addr_b];
        end
    end

    // Entry valid bits, cleared at the start of each compute.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_sets) begin
            r_set_vld  <= '0;
            r_rd_a_vld <= 1'b0;
            r_rd_b_vld <= 1'b0;
        end else begin
            if (w_en) r_set_vld[w_addr] <= 1'b1;
            if (rd_en) begin
                r_rd_a_vld <= r_set_vld[addr_a];
                r_rd_b_vld <= r_set_vld[addr_b];
            end
        end
    end

    // Pass change flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_changed) r_changed <= 1'b0;
        else if (set_changed)              r_changed <= 1'b1;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT_ROW || i_cmd.op == OP_EMIT_FAULT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT_ROW) begin
            o_table_kind <= i_cmd.row_kind;
            o_row_symbol <= i_cmd.row_sym;
            o_members    <= set_a;
            o_status     <= ST_OK;
            o_last       <= i_cmd.row_last;
        end else if (i_cmd.op == OP_EMIT_FAULT) begin
            o_table_kind <= 1'b0;
            o_row_symbol <= '0;
            o_members    <= '0;
            o_status     <= r_fault;
            o_last       <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_stat.fault      = (r_fault != ST_OK);
    assign o_stat.changed    = r_changed;
    assign o_stat.out_free   = ~r_out_valid | i_out_ready;
    assign o_stat.rule_total = r_rule_count + RCNT_W'(r_prep);
    assign o_stat.len        = r_rd_len;
    assign o_stat.term_count = r_term_count;

endmodule

// File: rtl/first_follow_set_builder.sv
// Sequence: one symbol per cycle while loading, then the grammar check.
// FIRST passes repeat over all productions until a pass changes nothing; FOLLOW seeding
// then walks each production of three symbols or more, and FOLLOW propagation passes
// repeat likewise. Rows then leave, each read in S_O0 and emitted in S_O1 when free.
// Throughput: one grammar at a time; input waits until its last result is issued.
// Reset (synchronous, active low) empties the store, clears the fault and loads defaults.
module first_follow_set_builder import ffsb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [SYM_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic              i_end_of_production,
    input  logic              i_end_of_grammar,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_table_kind,
    output logic [SYM_W-1:0]  o_row_symbol,
    output logic [SET_W-1:0]  o_members,
    output logic [2:0]        o_status,
    output logic              o_last
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    ffsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_eog      (i_end_of_grammar),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Storage and set arithmetic.
    ffsb_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_symbol            (i_symbol),
        .i_end_of_production (i_end_of_production),
        .i_end_of_grammar    (i_end_of_grammar),
        .i_out_ready         (i_out_ready),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_out_valid         (o_out_valid),
        .o_table_kind        (o_table_kind),
        .o_row_symbol        (o_row_symbol),
        .o_members           (o_members),
        .o_status            (o_status),
        .o_last              (o_last)
    );

endmodule

// File: rtl/ffsb_checker.sv
// Port-level checks for the FIRST/FOLLOW set builder, bound to the top
// level. Uses ffsb_pkg.
module ffsb_checker import ffsb_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_table_kind,
    input logic [SYM_W-1:0]  o_row_symbol,
    input logic [SET_W-1:0]  o_members,
    input logic [2:0]        o_status,
    input logic              o_last
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_members)
            && $stable(o_last))
        else $error("result changed while stalled");

    // No new grammar is taken while rows of a run are still pending.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input ready during row emission");

    // A fault result stands alone with empty fields.
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_last && o_members == '0
            && o_row_symbol == '0 && !o_table_kind)
        else $error("malformed fault result");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind first_follow_set_builder ffsb_checker u_chk (.*);

// File: test/first_follow_set_builder_tb.sv
// Self-checking testbench for the FIRST/FOLLOW set builder: loads random and
// directed grammars, predicts every FIRST/FOLLOW row or fault, and compares.
// Depends on rtl/ffsb_pkg.sv and rtl/first_follow_set_builder.sv.
`timescale 1ns / 100ps

module first_follow_set_builder_tb;
    import ffsb_pkg::*;

    typedef struct {
        logic [SYM_W-1:0] sym;
        logic             eop;
        logic             eog;
    } t_item;

    typedef struct {
        logic             kind;
        logic [SYM_W-1:0] row;
        logic [SET_W-1:0] members;
        logic [2:0]       status;
        logic             last;
    } t_row;

    typedef enum int {
        G_PLAIN, G_START_OK, G_START_BAD, G_LHS_TERM, G_SHORT, G_LONG, G_MANY, G_FULL
    } t_shape;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [SYM_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 0;
    logic              o_in_ready;
    logic [SYM_W-1:0]  i_symbol = '0;
    logic              i_end_of_production = 0;
    logic              i_end_of_grammar = 0;
    logic              o_out_valid;
    logic              i_out_ready = 0;
    logic              o_table_kind;
    logic [SYM_W-1:0]  o_row_symbol;
    logic [SET_W-1:0]  o_members;
    logic [2:0]        o_status;
    logic              o_last;

    first_follow_set_builder DUT (.*);

    // Clock: 12 ns period.
    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // Testbench copy of the registers and the grammar store.
    logic [SYM_W-1:0] term_cnt = 5'd16, start_sym = 5'd31, end_sym = 5'd0;
    logic [SYM_W-1:0] store_sym [MAX_RULES][MAX_RULE_LEN];
    logic [POS_W-1:0] store_len [MAX_RULES];
    int               rules_held = 0;
    int               fill_pos = 0;
    logic [2:0]       fault_code = ST_OK;
    logic [SET_W-1:0] first_tab [32];
    logic [SET_W-1:0] follow_tab [32];

    t_item pending_items[$];
    t_row  expected_rows[$];
    t_item next_item;
    int    errors = 0, rows_checked = 0, grammars_sent = 0, faults_seen = 0;
    bit    calm = 0, hold_req = 0, hold_done = 0;
    int    hold_left = 0;

    // Append one symbol transaction to the stimulus queue.
    function automatic void enqueue_item(logic [SYM_W-1:0] s, logic eop, logic eog);
        t_item it;
        it.sym = s;
        it.eop = eop;
        it.eog = eog;
        pending_items = {pending_items, it};
    endfunction

    // Append one predicted result to the scoreboard.
    function automatic void expect_row(t_row r);
        expected_rows = {expected_rows, r};
    endfunction

    function automatic bit terminal(logic [SYM_W-1:0] s);
        return s < term_cnt;
    endfunction

    function automatic logic [SET_W-1:0] first_set_of(logic [SYM_W-1:0] s);
        return terminal(s) ? (32'd1 << s) : first_tab[s];
    endfunction

    function automatic void note_fault(logic [2:0] code);
        if (fault_code == ST_OK) fault_code = code;
    endfunction

    // Prepend START -> first left side, or check the given START production.
    function automatic void add_start_rule();
        logic [SYM_W-1:0] lhs;
        lhs = store_sym[0][0];
        if (lhs == start_sym) begin
            if (store_len[0] != 2 || terminal(store_sym[0][1])) note_fault(ST_BAD_START);
            return;
        end
        if (rules_held >= MAX_RULES) begin
            note_fault(ST_OVERFLOW);
            return;
        end
        for (int r = rules_held; r > 0; r--) begin
            store_sym[r] = store_sym[r-1];
            store_len[r] = store_len[r-1];
        end
        store_sym[0][0] = start_sym;
        store_sym[0][1] = lhs;
        store_len[0] = POS_W'(2);
        rules_held++;
    endfunction

    // Fixpoint of FIRST, then FOLLOW seeding and propagation.
    function automatic void solve_sets();
        bit changed;
        logic [SYM_W-1:0] m, n;
        logic [SET_W-1:0] nv;
        for (int k = 0; k < 32; k++) begin
            first_tab[k] = '0;
            follow_tab[k] = '0;
        end
        do begin
            changed = 0;
            for (int r = 0; r < rules_held; r++) begin
                n = store_sym[r][0];
                nv = first_tab[n] | first_set_of(store_sym[r][1]);
                if (nv != first_tab[n]) begin
                    first_tab[n] = nv;
                    changed = 1;
                end
            end
        end while (changed);
        follow_tab[start_sym] |= 32'd1 << end_sym;
        for (int r = 0; r < rules_held; r++)
            for (int j = 1; j + 1 < store_len[r]; j++)
                if (!terminal(store_sym[r][j]))
                    follow_tab[store_sym[r][j]] |= first_set_of(store_sym[r][j+1]);
        do begin
            changed = 0;
            for (int r = 0; r < rules_held; r++) begin
                m = store_sym[r][0];
                n = store_sym[r][store_len[r] - 1];
                if (!terminal(n) && m != n) begin
                    nv = follow_tab[n] | follow_tab[m];
                    if (nv != follow_tab[n]) begin
                        follow_tab[n] = nv;
                        changed = 1;
                    end
                end
            end
        end while (changed);
    endfunction

    // Advance the prediction by one accepted symbol transaction.
    function automatic void predict_symbol(t_item it);
        t_row r;
        if (fill_pos == 0 && terminal(it.sym)) note_fault(ST_LHS_TERM);
        if (rules_held >= MAX_RULES || fill_pos >= MAX_RULE_LEN) note_fault(ST_OVERFLOW);
        else store_sym[rules_held][fill_pos] = it.sym;
        fill_pos = (fill_pos < MAX_RULE_LEN) ? fill_pos + 1 : MAX_RULE_LEN;
        if (it.eop || it.eog) begin
            if (fill_pos < 2) note_fault(ST_SHORT);
            if (rules_held < MAX_RULES) begin
                store_len[rules_held] = POS_W'(fill_pos);
                rules_held++;
            end
            fill_pos = 0;
        end
        if (!it.eog) return;
        if (fault_code == ST_OK && rules_held > 0) add_start_rule();
        if (fault_code != ST_OK) begin
            r = '{1'b0, '0, '0, fault_code, 1'b1};
            expect_row(r);
        end else begin
            solve_sets();
            for (int k = term_cnt; k < NUM_SYMBOLS; k++) begin
                r = '{1'b0, k[SYM_W-1:0], first_tab[k], ST_OK, 1'b0};
                expect_row(r);
                r = '{1'b1, k[SYM_W-1:0], follow_tab[k], ST_OK, k == NUM_SYMBOLS - 1};
                expect_row(r);
            end
        end
        rules_held = 0;
        fill_pos = 0;
        fault_code = ST_OK;
    endfunction

    // Driver: offers queued symbols, idling now and then.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                predict_symbol('{i_symbol, i_end_of_production, i_end_of_grammar});
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
                    next_item = pending_items.pop_front();
                    i_in_valid <= 1;
                    i_symbol <= next_item.sym;
                    i_end_of_production <= next_item.eop;
                    i_end_of_grammar <= next_item.eog;
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1;
            i_out_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= calm || $urandom_range(99) >= 8;
        end
    end

    task automatic report_mismatch(string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Monitor: each result transaction against the oldest expected row.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rows.size() == 0) begin
                report_mismatch($sformatf("unexpected row sym %0d", o_row_symbol));
            end else begin
                automatic t_row e = expected_rows.pop_front();
                rows_checked++;
                if (e.status != ST_OK) faults_seen++;
                if (o_table_kind !== e.kind)
                    report_mismatch($sformatf("kind %0d want %0d", o_table_kind, e.kind));
                if (o_row_symbol !== e.row)
                    report_mismatch($sformatf("row %0d want %0d", o_row_symbol, e.row));
                if (o_members !== e.members)
                    report_mismatch($sformatf("row %0d members %h want %h",
                                              e.row, o_members, e.members));
                if (o_status !== e.status)
                    report_mismatch($sformatf("status %0d want %0d", o_status, e.status));
                if (o_last !== e.last)
                    report_mismatch($sformatf("last %0d want %0d", o_last, e.last));
            end
        end
    end

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [SYM_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_TERM_COUNT: term_cnt = val;
            CFG_START_SYM:  start_sym = val;
            default:        end_sym = val;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || i_in_valid || expected_rows.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [SYM_W-1:0] any_nonterm();
        return SYM_W'($urandom_range(31, term_cnt));
    endfunction

    // Queue one production; the grammar ends on it when closing is set.
    function automatic int add_rule(logic [SYM_W-1:0] lhs, int rhs_len, bit closing);
        enqueue_item(lhs, rhs_len == 0, closing && rhs_len == 0);
        for (int k = 1; k <= rhs_len; k++)
            enqueue_item(SYM_W'($urandom_range(31)), k == rhs_len,
                         closing && k == rhs_len);
        return rhs_len + 1;
    endfunction

    // Queue a whole grammar of the given shape; returns its item count.
    function automatic int add_grammar(t_shape shape);
        int total = 0, nrules;
        nrules = $urandom_range(4, 1);
        grammars_sent++;
        case (shape)
            G_START_OK: begin
                enqueue_item(start_sym, 1'b0, 1'b0);
                enqueue_item(any_nonterm(), 1'b1, 1'b0);
                total = 2;
            end
            G_START_BAD:
                total = add_rule(start_sym, $urandom_range(3, 1), 0);
            G_LHS_TERM:
                total = add_rule(SYM_W'($urandom_range(term_cnt - 1, 0)), 2, 0);
            G_SHORT:
                total = add_rule(any_nonterm(), 0, 0);
            G_LONG:
                total = add_rule(any_nonterm(), $urandom_range(12, 8), 0);
            G_MANY, G_FULL:
                nrules = (shape == G_MANY) ? 64 : 63;
            default: ;
        endcase
        for (int r = 0; r < nrules; r++)
            total += add_rule(any_nonterm(),
                              (shape == G_MANY || shape == G_FULL) ? 1 : $urandom_range(7, 1),
                              r == nrules - 1);
        return total;
    endfunction

    function automatic t_shape pick_shape();
        int p;
        p = $urandom_range(99);
        if (p < 60) return G_PLAIN;
        if (p < 75) return G_START_OK;
        if (p < 81) return G_START_BAD;
        if (p < 87) return G_LHS_TERM;
        if (p < 93) return G_SHORT;
        return G_LONG;
    endfunction

    // Stimulus: directed grammars, then random phases over several settings.
    initial begin
        int sent;
        logic [SYM_W-1:0] set_tc [6];
        logic [SYM_W-1:0] set_st [6];
        logic [SYM_W-1:0] set_end[6];
        set_tc  = '{5'd1, 5'd31, 5'd8, 5'd4, 5'd20, 5'd16};
        set_st  = '{5'd31, 5'd31, 5'd8, 5'd2, 5'd25, 5'd17};
        set_end = '{5'd31, 5'd0, 5'd5, 5'd3, 5'd17, 5'd9};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: START given, terminal left side, short
        // productions, bad START, extreme symbols.
        enqueue_item(5'd31, 1'b0, 1'b0);
        enqueue_item(5'd20, 1'b1, 1'b0);
        enqueue_item(5'd20, 1'b0, 1'b0);
        enqueue_item(5'd0, 1'b0, 1'b0);
        enqueue_item(5'd20, 1'b0, 1'b0);
        enqueue_item(5'd31, 1'b1, 1'b1);
        void'(add_grammar(G_LHS_TERM));
        void'(add_grammar(G_SHORT));
        void'(add_grammar(G_START_BAD));
        enqueue_item(5'd17, 1'b0, 1'b0);
        enqueue_item(5'd15, 1'b0, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_TERM_COUNT, set_tc[ph]);
            write_reg(CFG_START_SYM, set_st[ph]);
            write_reg(CFG_END_SYM, set_end[ph]);
            calm = (ph == 2);
            sent = 0;
            if (ph == 3) begin
                // Long receiver hold while two grammars queue up behind.
                hold_req = 1;
                sent += add_grammar(G_PLAIN);
                sent += add_grammar(G_START_OK);
            end
            if (ph == 4) begin
                // Store limit: a full store that leaves no room for the prepend.
                sent += add_grammar(G_MANY);
            end
            while (sent < 8) begin
                sent += add_grammar(pick_shape());
                // Sender pauses for all results now and then.
                if ($urandom_range(3) == 0) wait_idle();
            end
            wait_idle();
        end

        $display("tb: %0d grammars over 7 register settings, %0d rows checked (%0d faults)",
                 grammars_sent, rows_checked, faults_seen);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule
